@@ hdl/sta_pkg.sv @@
`timescale 1ns / 1ps
package sta_pkg;

  localparam int SLOTS     = 16384;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int MAX_NAME  = 128;
  localparam int CNT_W     = $clog2(MAX_NAME + 1);
  localparam int KEY_WORDS = (MAX_NAME + 7) / 8;
  localparam int KW_W      = $clog2(KEY_WORDS);
  localparam int KEY_DEPTH = SLOTS * KEY_WORDS;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [9:0] TEMP_MAX = 10'd999;
  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_READ = 2'd1,
    KIND_FULL = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_NAME = 3'b001,
    PH_TEMP = 3'b010,
    PH_SKIP = 3'b100
  } phase_t;

  // one table slot as kept in the slot memory
  typedef struct packed {
    logic               used;
    logic [7:0]         len;
    logic signed [10:0] mn;
    logic signed [10:0] mx;
    logic signed [47:0] sum;
    logic [31:0]        cnt;
  } meta_t;

  typedef struct packed {
    kind_t              kind;
    logic [13:0]        slot;
    logic               occupied;
    logic               inserted;
    logic [7:0]         name_len;
    logic signed [10:0] min_temp;
    logic signed [10:0] max_temp;
    logic signed [47:0] temp_sum;
    logic [31:0]        sample_count;
  } res_t;

  typedef struct packed {
    logic byte_take;
    logic read_rd;
    logic probe_start;
    logic meta_rd;
    logic slot_adv;
    logic word_adv;
    logic name_rd;
    logic key_rd;
    logic key_wr;
    logic clr_wr;
    logic res_read;
    logic res_ins;
    logic res_upd;
    logic res_full;
    logic res_long;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_nl;
    logic ph_temp;
    logic ph_skip;
    logic used;
    logic len_eq;
    logic name_empty;
    logic word_eq;
    logic w_last;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hdl/sta_ram.sv @@
`timescale 1ns / 1ps
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/sta_datapath.sv @@
`timescale 1ns / 1ps
module sta_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  sta_pkg::ctl_cmd_t        cmd,
  output sta_pkg::dp_sts_t         sts,
  input  logic [7:0]               in_byte,
  input  logic [sta_pkg::SLOT_W-1:0] in_read_slot,
  input  logic                     out_ready,
  output logic                     out_valid,
  output sta_pkg::res_t            out_res
);
  import sta_pkg::*;

  // line parse state
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SLOT_W-1:0] hash, hash_next;
  logic [63:0]       cur_word, cur_word_next;
  logic [9:0]        mag, mag_next;
  logic              neg, neg_next;

  // probe state
  logic [SLOT_W-1:0] slot, probes, clr_idx;
  logic [KW_W-1:0]   widx;
  res_t              res;
  logic [SLOT_W-1:0] read_slot_q;

  logic              name_wr;
  logic [63:0]       name_wr_data;
  logic [63:0]       name_rd_data, key_rd_data, word_ins;
  meta_t             meta_q, meta_wr_data, ins_meta, upd_meta;
  logic              meta_wr;
  logic [SLOT_W-1:0] meta_wr_addr, meta_rd_addr;
  logic [KW_W:0]     nw;
  logic [CNT_W:0]    nw_full;
  logic [13:0]       mag_mul;
  logic [3:0]        digit;
  logic              is_digit, line_clear;
  logic signed [10:0] t;

  assign digit    = in_byte[3:0] - CH_ZERO[3:0];
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign mag_mul  = {4'b0, mag} * 14'd10 + {10'b0, digit};
  assign word_ins = cur_word | ({56'b0, in_byte} << {count[2:0], 3'b000});
  assign t        = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign nw_full  = {1'b0, count} + (CNT_W+1)'(7);
  assign nw       = nw_full[KW_W+3:3];
  assign line_clear = cmd.res_ins | cmd.res_upd | cmd.res_full | cmd.res_long;

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    hash_next     = hash;
    cur_word_next = cur_word;
    mag_next      = mag;
    neg_next      = neg;
    name_wr       = 1'b0;
    name_wr_data  = cur_word;
    if (cmd.byte_take) begin
      unique case (phase)
        PH_NAME: begin
          if (in_byte == CH_NL) begin
            count_next    = '0;
            hash_next     = '0;
            cur_word_next = '0;
          end else if (in_byte == CH_SEMI) begin
            phase_next = PH_TEMP;
            if (count[2:0] != 3'd0) begin
              name_wr   = 1'b1;
              hash_next = hash + cur_word[SLOT_W-1:0];
            end
          end else if (count >= CNT_W'(MAX_NAME)) begin
            phase_next = PH_SKIP;
          end else begin
            count_next = count + 1'b1;
            if (count[2:0] == 3'd7) begin
              name_wr       = 1'b1;
              name_wr_data  = word_ins;
              hash_next     = hash + word_ins[SLOT_W-1:0];
              cur_word_next = '0;
            end else begin
              cur_word_next = word_ins;
            end
          end
        end
        PH_TEMP: begin
          if (in_byte == CH_MINUS) begin
            neg_next = 1'b1;
          end else if (is_digit) begin
            mag_next = (mag_mul > {4'b0, TEMP_MAX}) ? TEMP_MAX : mag_mul[9:0];
          end
        end
        PH_SKIP: begin
          // rest of an overlong line is dropped, the error goes out at newline
        end
        default: phase_next = PH_NAME;
      endcase
    end
    if (line_clear) begin
      phase_next    = PH_NAME;
      count_next    = '0;
      hash_next     = '0;
      cur_word_next = '0;
      mag_next      = '0;
      neg_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NAME;
      count    <= '0;
      hash     <= '0;
      cur_word <= '0;
      mag      <= '0;
      neg      <= 1'b0;
    end else begin
      phase    <= phase_next;
      count    <= count_next;
      hash     <= hash_next;
      cur_word <= cur_word_next;
      mag      <= mag_next;
      neg      <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      slot   <= hash;
      probes <= '0;
      widx   <= '0;
    end else if (cmd.slot_adv) begin
      slot   <= slot + 1'b1;
      probes <= probes + 1'b1;
      widx   <= '0;
    end else if (cmd.word_adv) begin
      widx <= widx + 1'b1;
    end
  end

  // new slot contents for insert and update
  always_comb begin
    ins_meta      = '0;
    ins_meta.used = 1'b1;
    ins_meta.len  = 8'(count);
    ins_meta.mn   = t;
    ins_meta.mx   = t;
    ins_meta.sum  = 48'(t);
    ins_meta.cnt  = 32'd1;
    upd_meta      = meta_q;
    if (t < meta_q.mn) upd_meta.mn = t;
    if (t > meta_q.mx) upd_meta.mx = t;
    if (meta_q.cnt != CNT_MAX) begin
      upd_meta.cnt = meta_q.cnt + 1'b1;
      upd_meta.sum = meta_q.sum + 48'(t);
    end
  end

  always_comb begin
    meta_wr      = cmd.clr_wr | cmd.res_ins | cmd.res_upd;
    meta_wr_addr = cmd.clr_wr ? clr_idx : slot;
    meta_wr_data = cmd.clr_wr ? meta_t'('0) : (cmd.res_ins ? ins_meta : upd_meta);
    meta_rd_addr = cmd.read_rd ? in_read_slot : slot;
  end

  sta_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (cmd.meta_rd | cmd.read_rd),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_q)
  );

  sta_ram #(.WIDTH(64), .DEPTH(KEY_WORDS)) u_name_ram (
    .clk     (clk),
    .wr_en   (name_wr),
    .wr_addr (count[KW_W+2:3]),
    .wr_data (name_wr_data),
    .rd_en   (cmd.name_rd),
    .rd_addr (widx),
    .rd_data (name_rd_data)
  );

  sta_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (cmd.key_wr),
    .wr_addr ({slot, widx}),
    .wr_data (name_rd_data),
    .rd_en   (cmd.key_rd),
    .rd_addr ({slot, widx}),
    .rd_data (key_rd_data)
  );

  // readout slot is captured at request time
  always_ff @(posedge clk) begin
    if (cmd.read_rd) read_slot_q <= in_read_slot;
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_read || cmd.res_ins || cmd.res_upd) begin
      res.kind         <= cmd.res_read ? KIND_READ : KIND_LINE;
      res.slot         <= cmd.res_read ? read_slot_q : slot;
      res.inserted     <= cmd.res_ins;
      res.occupied     <= cmd.res_ins ? 1'b1 : meta_q.used;
      res.name_len     <= cmd.res_ins ? ins_meta.len :
                          (cmd.res_read ? meta_q.len : upd_meta.len);
      res.min_temp     <= cmd.res_ins ? ins_meta.mn :
                          (cmd.res_read ? meta_q.mn : upd_meta.mn);
      res.max_temp     <= cmd.res_ins ? ins_meta.mx :
                          (cmd.res_read ? meta_q.mx : upd_meta.mx);
      res.temp_sum     <= cmd.res_ins ? ins_meta.sum :
                          (cmd.res_read ? meta_q.sum : upd_meta.sum);
      res.sample_count <= cmd.res_ins ? ins_meta.cnt :
                          (cmd.res_read ? meta_q.cnt : upd_meta.cnt);
    end else if (cmd.res_full || cmd.res_long) begin
      res <= {(cmd.res_full ? KIND_FULL : KIND_LONG), {($bits(res_t)-2){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res <= res;
    end
  end

  always_comb begin
    sts.is_nl      = (in_byte == CH_NL);
    sts.ph_temp    = (phase == PH_TEMP);
    sts.ph_skip    = (phase == PH_SKIP);
    sts.used       = meta_q.used;
    sts.len_eq     = (meta_q.len == 8'(count));
    sts.name_empty = (count == '0);
    sts.word_eq    = (name_rd_data == key_rd_data);
    sts.w_last     = ({1'b0, widx} + 1'b1 == nw);
    sts.probe_last = (probes == {SLOT_W{1'b1}});
    sts.clr_last   = (clr_idx == {SLOT_W{1'b1}});
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

@@ hdl/sta_controller.sv @@
`timescale 1ns / 1ps
module sta_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  input  sta_pkg::dp_sts_t   sts,
  output sta_pkg::ctl_cmd_t  cmd
);
  import sta_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR     = 12'b000000000001,
    ST_IDLE      = 12'b000000000010,
    ST_RD_META   = 12'b000000000100,
    ST_PROBE_RD  = 12'b000000001000,
    ST_PROBE_CHK = 12'b000000010000,
    ST_COPY_RD   = 12'b000000100000,
    ST_COPY_WR   = 12'b000001000000,
    ST_INSERT    = 12'b000010000000,
    ST_CMP_RD    = 12'b000100000000,
    ST_CMP_CHK   = 12'b001000000000,
    ST_UPDATE    = 12'b010000000000,
    ST_EMIT      = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command) begin
            cmd.read_rd = 1'b1;
            state_next  = ST_RD_META;
          end else begin
            cmd.byte_take = 1'b1;
            if (sts.is_nl && sts.ph_temp) begin
              cmd.probe_start = 1'b1;
              state_next      = ST_PROBE_RD;
            end else if (sts.is_nl && sts.ph_skip) begin
              cmd.res_long = 1'b1;
              state_next   = ST_EMIT;
            end
          end
        end
      end
      ST_RD_META: begin
        cmd.res_read = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_PROBE_RD: begin
        cmd.meta_rd = 1'b1;
        state_next  = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (!sts.used) begin
          state_next = sts.name_empty ? ST_INSERT : ST_COPY_RD;
        end else if (sts.len_eq) begin
          state_next = sts.name_empty ? ST_UPDATE : ST_CMP_RD;
        end else if (sts.probe_last) begin
          cmd.res_full = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          cmd.slot_adv = 1'b1;
          state_next   = ST_PROBE_RD;
        end
      end
      ST_COPY_RD: begin
        cmd.name_rd = 1'b1;
        state_next  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.key_wr = 1'b1;
        if (sts.w_last) begin
          state_next = ST_INSERT;
        end else begin
          cmd.word_adv = 1'b1;
          state_next   = ST_COPY_RD;
        end
      end
      ST_INSERT: begin
        cmd.res_ins = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_CMP_RD: begin
        cmd.name_rd = 1'b1;
        cmd.key_rd  = 1'b1;
        state_next  = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (sts.word_eq) begin
          if (sts.w_last) begin
            state_next = ST_UPDATE;
          end else begin
            cmd.word_adv = 1'b1;
            state_next   = ST_CMP_RD;
          end
        end else if (sts.probe_last) begin
          cmd.res_full = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          cmd.slot_adv = 1'b1;
          state_next   = ST_PROBE_RD;
        end
      end
      ST_UPDATE: begin
        cmd.res_upd = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ hdl/station_temperature_aggregator_core.sv @@
`timescale 1ns / 1ps
// Station temperature aggregator: takes "name;[-]d[d].d\n" text one byte per request and
// keeps min, max, sum and count per station name in a 16384-slot linearly probed table,
// hashed on the low bits of the sum of the name's 8-byte chunks. After reset the slot
// memory is cleared, and no request is taken until it is done. A newline that ends a line
// starts a probe: each slot is read from the registered slot memory and checked, and each
// 8-byte name word of a slot with the same name length is read and compared (or copied,
// for a new name); then the slot is inserted or updated and the result is built, or a full
// table is reported. A readout request reads one slot back; the newline of an overlong
// line gives an error. The output register lets the next request in while a result
// waits; a second result stalls until the first has been taken.
module station_temperature_aggregator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // data_byte[7:0], read_slot[21:8], zero pad
  input  logic         s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // slot, occupied, inserted, name_len, min_temp,
                                  // max_temp, temp_sum, sample_count, zero pad
  output logic [1:0]   m_tuser    // kind
);
  import sta_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  res_t     out_res;

  sta_controller u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser),
    .in_ready   (s_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sta_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (s_tdata[7:0]),
    .in_read_slot (s_tdata[SLOT_W+7:8]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_res      (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {2'b00, out_res.sample_count, out_res.temp_sum, out_res.max_temp,
                    out_res.min_temp, out_res.name_len, out_res.inserted,
                    out_res.occupied, out_res.slot};

endmodule

@@ hdl/sta_checker.sv @@
`timescale 1ns / 1ps
module sta_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [23:0]  s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import sta_pkg::*;

  // a waiting result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_FULL || m_tuser == KIND_LONG) |-> m_tdata == '0)
    else $error("error result carries data");

  a_line_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_LINE |-> m_tdata[14] && m_tdata[125:94] != 32'd0)
    else $error("line result on empty slot");

  a_insert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |->
      m_tuser == KIND_LINE && m_tdata[125:94] == 32'd1 && m_tdata[34:24] == m_tdata[45:35])
    else $error("insert result has bad stats");

endmodule

bind station_temperature_aggregator_core sta_checker u_sta_checker (.*);
